// File: hdl/plrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrs_pkg
// Shared types and display controller command codes for the paged lcd
// refresh sequencer.
// ----------------------------------------------------------------------------
package plrs_pkg;

	localparam int unsigned BYTE_W = 8;

	localparam logic [BYTE_W-1:0] CMD_PAGE     = 8'hB0;
	localparam logic [BYTE_W-1:0] CMD_COL_LOW  = 8'h00;
	localparam logic [BYTE_W-1:0] CMD_COL_HIGH = 8'h10;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// header step codes
	localparam logic [1:0] HDR_PAGE  = 2'd0;
	localparam logic [1:0] HDR_LOW   = 2'd1;
	localparam logic [1:0] HDR_HIGH  = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HDR,
		ST_BURST
	} seq_state_t;

endpackage

// File: hdl/plrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrs_ram
// Generic simple dual-port ram: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module plrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/plrs_ptr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrs_ptr
// Refresh pointer: linear store index kept together with its page and column
// so that no division is needed for the page header.
// ----------------------------------------------------------------------------
module plrs_ptr #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 6
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        step,
	output logic [$clog2(COLUMNS*PAGES)-1:0]            ptr,
	output logic [((PAGES > 1) ? $clog2(PAGES) : 1)-1:0] page,
	output logic                                        page_start
);

	localparam int STORE_SIZE = COLUMNS * PAGES;
	localparam int AW = $clog2(STORE_SIZE);
	localparam int CW = $clog2(COLUMNS);
	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;

	logic [AW-1:0] ptr_q;
	logic [CW-1:0] col_q;
	logic [PW-1:0] page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			col_q  <= '0;
			page_q <= '0;
		end else if (step) begin
			if (ptr_q == AW'(STORE_SIZE - 1)) begin
				ptr_q  <= '0;
				col_q  <= '0;
				page_q <= '0;
			end else begin
				ptr_q <= ptr_q + AW'(1);
				if (col_q == CW'(COLUMNS - 1)) begin
					col_q  <= '0;
					page_q <= page_q + PW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	assign ptr        = ptr_q;
	assign page       = page_q;
	assign page_start = (col_q == '0);

endmodule

// File: hdl/paged_lcd_refresh_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_lcd_refresh_sequencer_top
// Frame store of PAGES x COLUMNS pixel column bytes with a refresh sequencer
// that sends page headers and bursts of display data.
// ----------------------------------------------------------------------------
//  channel   ports                              transaction
//  -------   --------------------------------   -----------------------------
//  item in   start, busy, action, address, data start & !busy at clk edge
//  result    strobe, out_byte, is_data,         strobe high for one cycle
//            last_of_run
//
//  after reset the store is cleared one byte a cycle, all COLUMNS*PAGES bytes
//  (768 by default), with busy high
//  a write leaves busy low; a header tick sends three bytes, one byte a cycle
//  a data tick reads BURST bytes, one frame store read a cycle on the
//  single read port; busy stays high until the registered read data is out
//  results cannot be stalled; strobe follows the read data directly
// ----------------------------------------------------------------------------
module paged_lcd_refresh_sequencer_top #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 6,
	parameter int BURST   = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [9:0]                  address,
	input  logic [plrs_pkg::BYTE_W-1:0] data,
	output logic                        strobe,
	output logic [plrs_pkg::BYTE_W-1:0] out_byte,
	output logic                        is_data,
	output logic                        last_of_run
);

	import plrs_pkg::*;

	localparam int STORE_SIZE = COLUMNS * PAGES;
	localparam int AW   = $clog2(STORE_SIZE);
	localparam int PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int BW   = (BURST > 1) ? $clog2(BURST) : 1;
	localparam int CNTW = (BW > 2) ? BW : 2;
	localparam int XW   = ((AW > 10) ? AW : 10) + 1;

	seq_state_t    state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] clr_q;
	logic          hdr_sent_q;
	logic          rd_valid_s1;
	logic          rd_last_s1;

	logic          accept;
	logic [XW-1:0] addr_x;
	logic          addr_ok;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic          ptr_step;
	logic          issue_last;
	logic [AW-1:0] ptr;
	logic [PW-1:0] page;
	logic          page_start;
	logic          hdr_out;

	assign busy    = (state_q != ST_IDLE) || rd_valid_s1;
	assign accept  = start && !busy;
	assign addr_x  = XW'(address);
	assign addr_ok = (addr_x < XW'(STORE_SIZE));

	plrs_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr),
		.rdata (ram_rdata)
	);

	plrs_ptr #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (ptr_step),
		.ptr        (ptr),
		.page       (page),
		.page_start (page_start)
	);

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(STORE_SIZE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cnt_d = '0;
				if (accept && action == ACT_TICK) begin
					if (page_start && !hdr_sent_q) begin
						state_d = ST_HDR;
					end else begin
						state_d = ST_BURST;
					end
				end
			end
			ST_HDR: begin
				cnt_d = cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(HDR_HIGH)) begin
					state_d = ST_IDLE;
				end
			end
			ST_BURST: begin
				cnt_d = cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(BURST - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and store control
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = AW'(addr_x);
		ram_wdata  = data;
		ptr_step   = 1'b0;
		issue_last = 1'b0;
		hdr_out    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_we = accept && action == ACT_WRITE && addr_ok;
			end
			ST_HDR: begin
				hdr_out = 1'b1;
			end
			ST_BURST: begin
				ptr_step   = 1'b1;
				issue_last = (cnt_q == CNTW'(BURST - 1));
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			clr_q       <= '0;
			hdr_sent_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rd_valid_s1 <= ptr_step;
			rd_last_s1  <= issue_last;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_HDR && cnt_q == CNTW'(HDR_HIGH)) begin
				hdr_sent_q <= 1'b1;
			end else if (state_q == ST_BURST) begin
				hdr_sent_q <= 1'b0;
			end
		end
	end

	// header bytes come from the state, data bytes from the store read
	always_comb begin
		strobe      = hdr_out || rd_valid_s1;
		is_data     = rd_valid_s1;
		last_of_run = rd_valid_s1 ? rd_last_s1 : (cnt_q == CNTW'(HDR_HIGH));
		out_byte    = ram_rdata;
		if (hdr_out) begin
			case (cnt_q[1:0])
				HDR_PAGE: out_byte = CMD_PAGE + BYTE_W'(page);
				HDR_LOW:  out_byte = CMD_COL_LOW;
				HDR_HIGH: out_byte = CMD_COL_HIGH;
				default:  out_byte = CMD_COL_HIGH;
			endcase
		end
	end

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !strobe)
		else $error("result during store clear");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(hdr_out && rd_valid_s1))
		else $error("header and data results overlap");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid_s1 && rd_last_s1) |=> !rd_valid_s1)
		else $error("data result after last of run");

	a_hdr_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HDR && cnt_q == CNTW'(HDR_HIGH)) |=>
			(hdr_sent_q && state_q == ST_IDLE))
		else $error("header end did not set header flag");

	a_idle_when_strobe_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q) == ST_BURST)
		else $error("data result without a preceding read");

endmodule

// File: test/tb_paged_lcd_refresh_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paged_lcd_refresh_sequencer_top
// Self-checking bench for the paged lcd refresh sequencer. Write and refresh
// transactions are driven through the start/busy handshake. A model of the
// frame store, refresh pointer and header flag in the bench predicts every
// command and data byte. Each strobed byte is checked in order against that
// prediction.
// ----------------------------------------------------------------------------
module tb_paged_lcd_refresh_sequencer_top;
	import plrs_pkg::*;

	localparam int COLUMNS     = 128;
	localparam int PAGES       = 6;
	localparam int BURST       = 4;
	localparam int STORE_BYTES = COLUMNS * PAGES;
	localparam int RAND_ITEMS  = 400;
	localparam int QUIET_TAIL  = 60;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              is_dat;
		logic              last;
	} lcd_byte_t;

	class lcd_stream_model;
		logic [BYTE_W-1:0] pixels [STORE_BYTES];
		int unsigned       ptr;
		bit                hdr_done;
		lcd_byte_t         pending_bytes [$];
		int                errors;

		function new();
			foreach (pixels[i]) pixels[i] = '0;
			ptr      = 0;
			hdr_done = 0;
			errors   = 0;
		endfunction

		// called on every accepted transaction
		function void accept_item(logic act, logic [9:0] addr, logic [BYTE_W-1:0] dat);
			if (act == ACT_WRITE) begin
				if (addr < STORE_BYTES) pixels[addr] = dat;
				return;
			end
			if (ptr >= STORE_BYTES) ptr = 0;
			if (ptr % COLUMNS == 0 && !hdr_done) begin
				pending_bytes.push_back('{CMD_PAGE + BYTE_W'(ptr / COLUMNS), 1'b0, 1'b0});
				pending_bytes.push_back('{CMD_COL_LOW, 1'b0, 1'b0});
				pending_bytes.push_back('{CMD_COL_HIGH, 1'b0, 1'b1});
				hdr_done = 1;
				return;
			end
			for (int k = 0; k < BURST; k++) begin
				pending_bytes.push_back('{pixels[ptr], 1'b1, 1'(k == BURST - 1)});
				ptr++;
				if (ptr >= STORE_BYTES) ptr = 0;
			end
			hdr_done = 0;
		endfunction

		function void check_byte(logic [BYTE_W-1:0] value, logic is_dat, logic last);
			lcd_byte_t want;
			if (pending_bytes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected byte: out_byte=%02h is_data=%0b last_of_run=%0b",
						value, is_dat, last);
				return;
			end
			want = pending_bytes.pop_front();
			if (want.value !== value || want.is_dat !== is_dat || want.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
						want.value, want.is_dat, want.last, value, is_dat, last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              action;
	logic [9:0]        address;
	logic [BYTE_W-1:0] data;
	logic              strobe;
	logic [BYTE_W-1:0] out_byte;
	logic              is_data;
	logic              last_of_run;
	int                cycle_count;

	lcd_stream_model sb = new();

	paged_lcd_refresh_sequencer_top #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES),
		.BURST  (BURST)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.address    (address),
		.data       (data),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.is_data    (is_data),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// start stays high into the next transaction unless a gap is inserted
	task automatic send_item(input logic act, input logic [9:0] addr,
			input logic [BYTE_W-1:0] dat);
		@(negedge clk);
		start   <= 1'b1;
		action  <= act;
		address <= addr;
		data    <= dat;
		do @(posedge clk); while (busy);
		sb.accept_item(act, addr, dat);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (strobe === 1'b1) sb.check_byte(out_byte, is_data, last_of_run);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [9:0]        addr;
		logic              act;
		logic [BYTE_W-1:0] dat;

		arst_n  = 1'b0;
		start   = 1'b0;
		action  = ACT_WRITE;
		address = '0;
		data    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: header and data on a fresh store, store edges, ignored writes
		send_item(ACT_TICK, 10'd0, 8'h00);
		send_item(ACT_TICK, 10'd0, 8'h00);
		send_item(ACT_WRITE, 10'd0, 8'hFF);
		send_item(ACT_WRITE, 10'd767, 8'hFF);
		send_item(ACT_WRITE, 10'd768, 8'hAA);
		send_item(ACT_WRITE, 10'd1023, 8'h55);
		send_item(ACT_WRITE, 10'd512, 8'h3C);
		send_item(ACT_WRITE, 10'd4, 8'h00);
		send_item(ACT_WRITE, 10'd5, 8'hFF);
		send_item(ACT_WRITE, 10'd6, 8'h81);
		send_item(ACT_WRITE, 10'd7, 8'h7E);
		send_item(ACT_TICK, 10'h3FF, 8'hFF);
		send_item(ACT_WRITE, 10'd8, 8'h01);
		send_item(ACT_WRITE, 10'd11, 8'h80);
		send_item(ACT_TICK, 10'd0, 8'h00);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			act = ($urandom_range(0, 9) < 6) ? ACT_TICK : ACT_WRITE;
			dat = BYTE_W'($urandom_range(0, 255));
			case ($urandom_range(0, 7))
				0: addr = 10'($urandom_range(STORE_BYTES, 1023));
				1, 2, 3: addr = 10'((sb.ptr + $urandom_range(0, 15)) % STORE_BYTES);
				default: addr = 10'($urandom_range(0, STORE_BYTES - 1));
			endcase
			send_item(act, addr, dat);
			if (i == RAND_ITEMS / 3) begin
				// let the block drain completely once mid-run
				hold_off(1);
				while (sb.pending_bytes.size() != 0) @(posedge clk);
			end else if (i < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
				hold_off($urandom_range(1, 11));
			end
		end

		hold_off(1);
		while (sb.pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		sb.errors += sb.pending_bytes.size();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
hdl/plrs_pkg.sv
hdl/plrs_ram.sv
hdl/plrs_ptr.sv
hdl/paged_lcd_refresh_sequencer_top.sv
test/tb_paged_lcd_refresh_sequencer_top.sv
